// ----- hw/rtl/acflw_pkg.sv -----
// Shared types and constants for the associative write-back cache.
// Used by the controller, datapath and top level.
package acflw_pkg;
   localparam int ENTRIES   = 16;
   localparam int SLOT_BITS = 4;
   localparam int CNT_BITS  = 5;
   localparam int ADDR_BITS = 32;
   localparam int DATA_BITS = 32;

   localparam logic [2:0] REQ_READ  = 3'd0;
   localparam logic [2:0] REQ_FILL  = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_INVAL = 3'd3;
   localparam logic [2:0] REQ_DUMP  = 3'd4;

   localparam logic CSR_USE_LRU = 1'b0;
   localparam logic CSR_ENTRIES = 1'b1;

   typedef struct packed {
      logic       load;      // latch request
      logic       exec;      // perform the latched non-dump request
      logic       dump_step; // advance dump scan
      logic       dump_start;
   } cmd_type;

   typedef struct packed {
      logic       dump_done;
   } sts_type;
endpackage

// ----- hw/rtl/acflw_ctrl.sv -----
// Controller for the cache: sequences request load, execute and dump scan.
// Depends on acflw_pkg.
module acflw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic               out_busy,
   output acflw_pkg::cmd_type cmd,
   input  acflw_pkg::sts_type sts
);
   import acflw_pkg::*;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DUMP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       is_dump_ff, is_dump_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      is_dump_in     = is_dump_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               is_dump_in = (req_type == REQ_DUMP);
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!out_busy) begin
               if (is_dump_ff) begin
                  cmd.dump_start = 1'b1;
                  state_in       = ST_DUMP;
               end else begin
                  cmd.exec = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DUMP: begin
            if (!out_busy) begin
               cmd.dump_step = 1'b1;
               if (sts.dump_done) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         is_dump_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         is_dump_ff <= is_dump_in;
      end
   end
endmodule

// ----- hw/rtl/acflw_dp.sv -----
// Datapath: tag/data/valid/dirty/rank arrays, counters and result register.
// Depends on acflw_pkg; commanded by acflw_ctrl.
module acflw_dp (
   input  logic               clock,
   input  logic               reset,
   input  acflw_pkg::cmd_type cmd,
   output acflw_pkg::sts_type sts,
   output logic               out_busy,
   input  logic [2:0]         req_type,
   input  logic [31:0]        req_address,
   input  logic [31:0]        req_data,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [4:0]         csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [31:0]        rsp_read_data,
   output logic               rsp_evict_valid,
   output logic [31:0]        rsp_evict_address,
   output logic [31:0]        rsp_evict_data,
   output logic               rsp_dump_valid,
   output logic [31:0]        rsp_dump_address,
   output logic [31:0]        rsp_dump_data,
   output logic [31:0]        rsp_hit_total,
   output logic [31:0]        rsp_miss_total,
   output logic               rsp_last
);
   import acflw_pkg::*;

   logic [ADDR_BITS-1:0] tag_ff [ENTRIES];
   logic [DATA_BITS-1:0] dat_ff [ENTRIES];
   logic [ENTRIES-1:0]   vld_ff, drt_ff;
   logic [SLOT_BITS-1:0] rank_ff [ENTRIES];
   logic [CNT_BITS-1:0]  occ_ff;
   logic [31:0]          hits_ff, miss_ff;
   logic                 lru_ff;
   logic [CNT_BITS-1:0]  cap_ff;
   logic [2:0]           type_ff;
   logic [31:0]          addr_ff, wdat_ff;
   logic [SLOT_BITS:0]   scan_ff;
   logic                 found_any_ff;

   logic                 ov_ff, o_hit_ff, o_ev_ff, o_dv_ff, o_last_ff;
   logic [31:0]          o_rd_ff, o_ea_ff, o_ed_ff, o_da_ff, o_dd_ff;

   assign out_busy = ov_ff && rsp_stall;

   // lookup
   logic                 hit_w, vict_w, free_w;
   logic [SLOT_BITS-1:0] hs_w, vs_w, fs_w;
   always_comb begin
      hit_w = 1'b0; hs_w = '0; vict_w = 1'b0; vs_w = '0;
      for (int i = ENTRIES-1; i >= 0; i--) begin
         if (vld_ff[i] && tag_ff[i] == addr_ff) begin
            hit_w = 1'b1; hs_w = SLOT_BITS'(i);
         end
         if (vld_ff[i] && rank_ff[i] == '0) begin
            vict_w = 1'b1; vs_w = SLOT_BITS'(i);
         end
      end
   end

   logic [CNT_BITS-1:0] cap_w;
   always_comb begin
      cap_w = cap_ff;
      if (cap_ff == '0) cap_w = CNT_BITS'(1);
      if (cap_ff > CNT_BITS'(ENTRIES)) cap_w = CNT_BITS'(ENTRIES);
   end
   logic evict_w;
   assign evict_w = (occ_ff >= cap_w) && (occ_ff != '0) && vict_w;

   // free slot search after possible eviction
   logic [ENTRIES-1:0] vld_after;
   always_comb begin
      vld_after = vld_ff;
      if (evict_w) vld_after[vs_w] = 1'b0;
      free_w = 1'b0; fs_w = '0;
      for (int i = ENTRIES-1; i >= 0; i--)
         if (!vld_after[i]) begin
            free_w = 1'b1; fs_w = SLOT_BITS'(i);
         end
   end

   logic [SLOT_BITS:0] scan_w;
   logic               dirty_at;
   assign scan_w   = cmd.dump_start ? '0 : scan_ff;
   assign dirty_at = vld_ff[scan_w[SLOT_BITS-1:0]] && drt_ff[scan_w[SLOT_BITS-1:0]];
   assign sts.dump_done  = (scan_w == (SLOT_BITS+1)'(ENTRIES-1));

   logic [CNT_BITS-1:0] occm1;
   assign occm1 = (occ_ff != '0) ? occ_ff - CNT_BITS'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0; drt_ff <= '0; occ_ff <= '0;
         hits_ff <= '0; miss_ff <= '0;
         lru_ff <= 1'b1; cap_ff <= CNT_BITS'(16);
         ov_ff <= 1'b0; scan_ff <= '0; found_any_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_USE_LRU) lru_ff <= csr_data[0];
            else cap_ff <= csr_data;
         end
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         if (cmd.load) begin
            type_ff <= req_type; addr_ff <= req_address; wdat_ff <= req_data;
         end
         if (cmd.exec) begin
            ov_ff <= 1'b1; o_last_ff <= 1'b1;
            o_hit_ff <= 1'b0; o_rd_ff <= '0; o_ev_ff <= 1'b0; o_ea_ff <= '0;
            o_ed_ff <= '0; o_dv_ff <= 1'b0; o_da_ff <= '0; o_dd_ff <= '0;
            unique case (type_ff)
               REQ_READ: begin
                  if (hit_w) begin
                     o_hit_ff <= 1'b1; o_rd_ff <= dat_ff[hs_w];
                     if (hits_ff != '1) hits_ff <= hits_ff + 32'd1;
                     if (lru_ff) begin
                        for (int i = 0; i < ENTRIES; i++)
                           if (vld_ff[i] && rank_ff[i] > rank_ff[hs_w])
                              rank_ff[i] <= rank_ff[i] - SLOT_BITS'(1);
                        rank_ff[hs_w] <= occm1[SLOT_BITS-1:0];
                     end
                  end else if (miss_ff != '1) miss_ff <= miss_ff + 32'd1;
               end
               REQ_WRITE: begin
                  if (hit_w) begin
                     dat_ff[hs_w] <= wdat_ff; drt_ff[hs_w] <= 1'b1;
                     if (lru_ff) begin
                        for (int i = 0; i < ENTRIES; i++)
                           if (vld_ff[i] && rank_ff[i] > rank_ff[hs_w])
                              rank_ff[i] <= rank_ff[i] - SLOT_BITS'(1);
                        rank_ff[hs_w] <= occm1[SLOT_BITS-1:0];
                     end
                  end
               end
               REQ_FILL: begin
                  if (hit_w) begin
                     dat_ff[hs_w] <= wdat_ff; drt_ff[hs_w] <= 1'b0;
                     if (lru_ff) begin
                        for (int i = 0; i < ENTRIES; i++)
                           if (vld_ff[i] && rank_ff[i] > rank_ff[hs_w])
                              rank_ff[i] <= rank_ff[i] - SLOT_BITS'(1);
                        rank_ff[hs_w] <= occm1[SLOT_BITS-1:0];
                     end
                  end else begin
                     if (evict_w) begin
                        if (drt_ff[vs_w]) begin
                           o_ev_ff <= 1'b1; o_ea_ff <= tag_ff[vs_w];
                           o_ed_ff <= dat_ff[vs_w];
                        end
                        for (int i = 0; i < ENTRIES; i++)
                           if (vld_ff[i] && rank_ff[i] != '0)
                              rank_ff[i] <= rank_ff[i] - SLOT_BITS'(1);
                        vld_ff[vs_w] <= 1'b0; drt_ff[vs_w] <= 1'b0;
                     end
                     if (free_w) begin
                        tag_ff[fs_w] <= addr_ff; dat_ff[fs_w] <= wdat_ff;
                        vld_ff[fs_w] <= 1'b1; drt_ff[fs_w] <= 1'b0;
                        rank_ff[fs_w] <= evict_w ? occm1[SLOT_BITS-1:0]
                                                 : occ_ff[SLOT_BITS-1:0];
                        occ_ff <= evict_w ? occ_ff : occ_ff + CNT_BITS'(1);
                     end else if (evict_w) occ_ff <= occm1;
                  end
               end
               REQ_INVAL: begin
                  vld_ff <= '0; drt_ff <= '0; occ_ff <= '0;
                  for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.dump_start || cmd.dump_step) begin
            if (cmd.dump_start) begin
               scan_ff <= '0; found_any_ff <= 1'b0;
            end else begin
               scan_ff <= scan_w + (SLOT_BITS+1)'(1);
               if (dirty_at) found_any_ff <= 1'b1;
               if (dirty_at || (sts.dump_done && !found_any_ff)) begin
                  ov_ff <= 1'b1; o_hit_ff <= 1'b0; o_rd_ff <= '0;
                  o_ev_ff <= 1'b0; o_ea_ff <= '0; o_ed_ff <= '0;
                  o_dv_ff <= dirty_at;
                  o_da_ff <= dirty_at ? tag_ff[scan_w[SLOT_BITS-1:0]] : '0;
                  o_dd_ff <= dirty_at ? dat_ff[scan_w[SLOT_BITS-1:0]] : '0;
                  o_last_ff <= sts.dump_done ||
                     ((vld_ff & drt_ff) >> (scan_w + (SLOT_BITS+1)'(1))) == '0;
               end
            end
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_hit = o_hit_ff;
   assign rsp_read_data = o_rd_ff;
   assign rsp_evict_valid = o_ev_ff;
   assign rsp_evict_address = o_ea_ff;
   assign rsp_evict_data = o_ed_ff;
   assign rsp_dump_valid = o_dv_ff;
   assign rsp_dump_address = o_da_ff;
   assign rsp_dump_data = o_dd_ff;
   assign rsp_hit_total = hits_ff;
   assign rsp_miss_total = miss_ff;
   assign rsp_last = o_last_ff;
endmodule

// ----- hw/rtl/assoc_cache_fifo_lru_writeback.sv -----
// Fully associative write-back cache of ENTRIES words with FIFO or LRU
// replacement (csr index 0) and a capacity limit (csr index 1). A read,
// fill, write, invalidate or unknown request gives one result with rsp_last
// set; its request is latched, then the result is registered, and no new
// request is taken until the controller is back in idle. A dump gives one
// result per dirty slot in slot order, or one empty result with rsp_last if
// none is dirty. It holds the input meanwhile and scans one slot per cycle
// while the result register is not held by rsp_stall.
// Top level; depends on acflw_pkg, acflw_ctrl and acflw_dp.
module assoc_cache_fifo_lru_writeback (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_address,
   input  logic [31:0] req_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [31:0] rsp_read_data,
   output logic        rsp_evict_valid,
   output logic [31:0] rsp_evict_address,
   output logic [31:0] rsp_evict_data,
   output logic        rsp_dump_valid,
   output logic [31:0] rsp_dump_address,
   output logic [31:0] rsp_dump_data,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic        rsp_last
);
   import acflw_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic    out_busy;

   assign csr_ready = 1'b1;

   acflw_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_type,
      .out_busy, .cmd, .sts
   );

   acflw_dp u_dp (
      .clock, .reset, .cmd, .sts, .out_busy,
      .req_type, .req_address, .req_data,
      .csr_valid(csr_valid && csr_ready), .csr_index, .csr_data,
      .rsp_valid, .rsp_stall, .rsp_hit, .rsp_read_data,
      .rsp_evict_valid, .rsp_evict_address, .rsp_evict_data,
      .rsp_dump_valid, .rsp_dump_address, .rsp_dump_data,
      .rsp_hit_total, .rsp_miss_total, .rsp_last
   );
endmodule

// ----- hw/rtl/acflw_checker.sv -----
// Port-level checks for the cache top level, bound in below.
// Depends only on the top level's ports.
module acflw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [31:0] rsp_read_data,
   input logic        rsp_dump_valid,
   input logic        rsp_evict_valid,
   input logic [31:0] rsp_hit_total
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("rsp dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("double accept");
   a_miss0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_data == '0) else $error("miss data");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_dump_valid && rsp_evict_valid)) else $error("mixed");
   a_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> rsp_hit_total >= $past(rsp_hit_total))
      else $error("hit total fell");
endmodule

bind assoc_cache_fifo_lru_writeback acflw_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_hit, .rsp_read_data, .rsp_dump_valid, .rsp_evict_valid, .rsp_hit_total
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the associative write-back cache.
// Depends on acflw_pkg and assoc_cache_fifo_lru_writeback.
`timescale 1ns / 100ps

module tb_top;
   import acflw_pkg::*;

   localparam logic [2:0] REQ_BAD_LO = 3'd5;
   localparam logic [2:0] REQ_BAD_HI = 3'd7;
   localparam int LIMIT = 3000;
   localparam int SETTLE = 2 * ENTRIES + 8;
   localparam int PEND_DEPTH = 256;
   localparam int EXP_DEPTH = 4096;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] addr;
      logic [31:0] wdata;
   } cache_req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_data;
      logic        evict_valid;
      logic [31:0] evict_address;
      logic [31:0] evict_data;
      logic        dump_valid;
      logic [31:0] dump_address;
      logic [31:0] dump_data;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic        last;
   } cache_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = '0;
   logic [31:0] req_address = '0;
   logic [31:0] req_data = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [4:0]  csr_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit, rsp_evict_valid, rsp_dump_valid, rsp_last;
   logic [31:0] rsp_read_data, rsp_evict_address, rsp_evict_data;
   logic [31:0] rsp_dump_address, rsp_dump_data, rsp_hit_total, rsp_miss_total;
   cache_rsp_type got;

   assoc_cache_fifo_lru_writeback dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_address(req_address), .req_data(req_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_read_data(rsp_read_data), .rsp_evict_valid(rsp_evict_valid),
      .rsp_evict_address(rsp_evict_address), .rsp_evict_data(rsp_evict_data),
      .rsp_dump_valid(rsp_dump_valid), .rsp_dump_address(rsp_dump_address),
      .rsp_dump_data(rsp_dump_data), .rsp_hit_total(rsp_hit_total),
      .rsp_miss_total(rsp_miss_total), .rsp_last(rsp_last)
   );

   assign got = {rsp_hit, rsp_read_data, rsp_evict_valid, rsp_evict_address,
                 rsp_evict_data, rsp_dump_valid, rsp_dump_address, rsp_dump_data,
                 rsp_hit_total, rsp_miss_total, rsp_last};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cache shadow
   logic [31:0] sh_tag [ENTRIES];
   logic [31:0] sh_data [ENTRIES];
   bit          sh_valid [ENTRIES];
   bit          sh_dirty [ENTRIES];
   int          sh_rank [ENTRIES];
   int          sh_occ;
   logic [31:0] sh_hits, sh_misses;
   bit          sh_lru = 1'b1;
   logic [4:0]  sh_cap = 5'd16;

   // pending requests and expected results, read and write indexes
   cache_req_type pend_buf [PEND_DEPTH];
   cache_rsp_type exp_buf [EXP_DEPTH];
   int          pend_rd = 0, pend_wr = 0, exp_rd = 0, exp_wr = 0;
   int          errors = 0, n_reqs = 0, n_rsps = 0, n_evicts = 0, n_dumped = 0;
   bit          quiet = 1'b0, hold_req = 1'b0, hold_done = 1'b0;
   int          addr_pool[20];

   function automatic int lookup(logic [31:0] a);
      for (int i = 0; i < ENTRIES; i++)
         if (sh_valid[i] && sh_tag[i] == a) return i;
      return -1;
   endfunction

   function automatic void make_youngest(int s);
      int r;
      r = sh_rank[s];
      for (int i = 0; i < ENTRIES; i++)
         if (sh_valid[i] && sh_rank[i] > r) sh_rank[i]--;
      sh_rank[s] = (sh_occ > 0) ? sh_occ - 1 : 0;
   endfunction

   function automatic cache_rsp_type totals_only();
      cache_rsp_type r;
      r = '0;
      r.hit_total = sh_hits;
      r.miss_total = sh_misses;
      return r;
   endfunction

   function automatic void exp_add(cache_rsp_type r);
      exp_buf[exp_wr] = r;
      exp_wr++;
   endfunction

   function automatic void predict_cache(cache_req_type q);
      cache_rsp_type r;
      int s, cap, v, n;
      s = lookup(q.addr);
      case (q.kind)
         REQ_READ: begin
            if (s >= 0) begin
               if (sh_hits != '1) sh_hits++;
               if (sh_lru) make_youngest(s);
            end else if (sh_misses != '1) sh_misses++;
            r = totals_only();
            if (s >= 0) begin
               r.hit = 1'b1;
               r.read_data = sh_data[s];
            end
            r.last = 1'b1;
            exp_add(r);
         end
         REQ_FILL: begin
            r = totals_only();
            cap = (sh_cap == 0) ? 1 : (sh_cap > ENTRIES) ? ENTRIES : sh_cap;
            if (s >= 0) begin
               sh_data[s] = q.wdata;
               sh_dirty[s] = 1'b0;
               if (sh_lru) make_youngest(s);
            end else begin
               if (sh_occ >= cap && sh_occ > 0) begin
                  v = -1;
                  for (int i = 0; i < ENTRIES; i++)
                     if (v < 0 && sh_valid[i] && sh_rank[i] == 0) v = i;
                  if (v >= 0) begin
                     if (sh_dirty[v]) begin
                        r.evict_valid = 1'b1;
                        r.evict_address = sh_tag[v];
                        r.evict_data = sh_data[v];
                     end
                     sh_valid[v] = 1'b0;
                     sh_dirty[v] = 1'b0;
                     for (int i = 0; i < ENTRIES; i++)
                        if (sh_valid[i] && sh_rank[i] > 0) sh_rank[i]--;
                     sh_occ--;
                  end
               end
               v = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (v < 0 && !sh_valid[i]) v = i;
               if (v >= 0) begin
                  sh_tag[v] = q.addr;
                  sh_data[v] = q.wdata;
                  sh_valid[v] = 1'b1;
                  sh_dirty[v] = 1'b0;
                  sh_rank[v] = sh_occ;
                  sh_occ++;
               end
            end
            r.last = 1'b1;
            exp_add(r);
         end
         REQ_WRITE: begin
            if (s >= 0) begin
               sh_data[s] = q.wdata;
               sh_dirty[s] = 1'b1;
               if (sh_lru) make_youngest(s);
            end
            r = totals_only();
            r.last = 1'b1;
            exp_add(r);
         end
         REQ_INVAL: begin
            for (int i = 0; i < ENTRIES; i++) begin
               sh_valid[i] = 1'b0;
               sh_dirty[i] = 1'b0;
               sh_rank[i] = 0;
            end
            sh_occ = 0;
            r = totals_only();
            r.last = 1'b1;
            exp_add(r);
         end
         REQ_DUMP: begin
            n = 0;
            for (int i = 0; i < ENTRIES; i++)
               if (sh_valid[i] && sh_dirty[i]) begin
                  r = totals_only();
                  r.dump_valid = 1'b1;
                  r.dump_address = sh_tag[i];
                  r.dump_data = sh_data[i];
                  exp_add(r);
                  n++;
               end
            if (n == 0) exp_add(totals_only());
            exp_buf[exp_wr - 1].last = 1'b1;
         end
         default: begin
            r = totals_only();
            r.last = 1'b1;
            exp_add(r);
         end
      endcase
   endfunction

   // driver
   int gap = 0;
   always @(posedge clock) begin
      bit            offer;
      cache_req_type nxt;
      offer = req_valid;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_cache('{req_type, req_address, req_data});
            n_reqs++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap > 0) gap--;
            else if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
            else if (pend_rd != pend_wr) begin
               nxt = pend_buf[pend_rd];
               pend_rd++;
               req_type <= nxt.kind;
               req_address <= nxt.addr;
               req_data <= nxt.wdata;
               offer = 1'b1;
            end
         end
      end
      req_valid <= offer;
   end

   // monitor and result check
   int stall_cnt = 0;
   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_rsps++;
            if (got.evict_valid) n_evicts++;
            if (got.dump_valid) n_dumped++;
            if (exp_rd == exp_wr) begin
               errors++;
               if (errors <= 10) $display("unexpected result %h", got);
            end else begin
               want = exp_buf[exp_rd];
               exp_rd++;
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp %h got %h (hit/rd/ev/evA/evD/dv/dA/dD/ht/mt/last)",
                        want, got);
               end
            end
         end
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            stall_cnt = 80;
         end else if (stall_cnt > 0) stall_cnt--;
         else if (!quiet && $urandom_range(0, 5) == 0) stall_cnt = $urandom_range(1, 11);
      end
      rsp_stall <= (stall_cnt > 0);
   end

   // watchdog on cycles without any transfer
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else if (!reset) idle_cycles++;
      if (idle_cycles >= LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   task automatic drain();
      while (pend_rd != pend_wr || req_valid || exp_rd != exp_wr) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [4:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_USE_LRU) sh_lru = val[0];
      else sh_cap = val;
   endtask

   task automatic push(logic [2:0] k, logic [31:0] a, logic [31:0] d);
      pend_buf[pend_wr] = '{k, a, d};
      pend_wr++;
   endtask

   task automatic push_random(int count);
      int sel;
      logic [31:0] a;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 19)];
         if (sel < 33)      push(REQ_READ, a, $urandom);
         else if (sel < 63) push(REQ_FILL, a, $urandom);
         else if (sel < 86) push(REQ_WRITE, a, $urandom);
         else if (sel < 90) push(REQ_INVAL, $urandom, $urandom);
         else if (sel < 97) push(REQ_DUMP, $urandom, $urandom);
         else push(3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)), a, $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         sh_valid[i] = 1'b0;
         sh_dirty[i] = 1'b0;
         sh_rank[i] = 0;
      end
      sh_occ = 0;
      sh_hits = '0;
      sh_misses = '0;
      addr_pool[0] = 32'h0;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 20; i++) addr_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every request kind at reset settings
      push(REQ_FILL, 32'h0, 32'hFFFF_FFFF);
      push(REQ_FILL, 32'hFFFF_FFFF, 32'h0);
      push(REQ_FILL, 32'h1234_5678, 32'hA5A5_5A5A);
      push(REQ_WRITE, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
      push(REQ_READ, 32'h0, 32'h0);
      push(REQ_READ, 32'hDEAD_BEEF, 32'h0);
      push(REQ_WRITE, 32'hDEAD_BEEF, 32'h1111_1111);  // write miss, no allocate
      push(REQ_WRITE, 32'h1234_5678, 32'h2222_2222);
      push(REQ_FILL, 32'hFFFF_FFFF, 32'h3333_3333);   // refill clears dirty
      push(REQ_DUMP, 32'h0, 32'h0);
      push(REQ_BAD_LO, 32'h0, 32'h0);
      push(REQ_BAD_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push(REQ_INVAL, 32'h0, 32'h0);
      push(REQ_DUMP, 32'h0, 32'h0);                   // nothing dirty
      push(REQ_READ, 32'h1234_5678, 32'h0);

      // single entry, FIFO: a written line is evicted dirty by the next fill
      csr_write(CSR_ENTRIES, 5'd1);
      csr_write(CSR_USE_LRU, 5'd0);
      push(REQ_FILL, 32'h0000_00AA, 32'h0000_0001);
      push(REQ_WRITE, 32'h0000_00AA, 32'hFFFF_FFFE);
      push(REQ_FILL, 32'h0000_00BB, 32'h0000_0002);
      push(REQ_READ, 32'h0000_00AA, 32'h0);
      push(REQ_READ, 32'h0000_00BB, 32'h0);

      // capacity zero acts as one
      csr_write(CSR_ENTRIES, 5'd0);
      push(REQ_WRITE, 32'h0000_00BB, 32'h0F0F_0F0F);
      push(REQ_FILL, 32'h0000_00CC, 32'h0);

      // full cache, LRU, long receiver hold-off to back up the input
      csr_write(CSR_ENTRIES, 5'd31);
      csr_write(CSR_USE_LRU, 5'd1);
      push(REQ_INVAL, 32'h0, 32'h0);
      for (int i = 0; i < ENTRIES; i++) push(REQ_FILL, addr_pool[i], $urandom);
      for (int i = 0; i < ENTRIES; i++) push(REQ_WRITE, addr_pool[i], $urandom);
      push(REQ_DUMP, 32'h0, 32'h0);
      hold_req = 1'b1;
      push_random(10);

      // shrink below occupancy, policy swapped with entries in place
      csr_write(CSR_ENTRIES, 5'd4);
      csr_write(CSR_USE_LRU, 5'd0);
      push_random(12);

      csr_write(CSR_ENTRIES, 5'd17);
      csr_write(CSR_USE_LRU, 5'd1);
      push_random(12);

      csr_write(CSR_ENTRIES, 5'd10);
      push_random(8);
      drain();

      // closing stretch without idling
      quiet = 1'b1;
      csr_write(CSR_USE_LRU, 5'd0);
      push_random(12);
      drain();

      $display("%0d requests, %0d results, %0d write-backs, %0d dumped lines; %0d errors",
         n_reqs, n_rsps, n_evicts, n_dumped, errors);
      $display("policies FIFO and LRU, capacities 0 to 31, input back-pressure exercised");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/acflw_pkg.sv
hw/rtl/acflw_ctrl.sv
hw/rtl/acflw_dp.sv
hw/rtl/assoc_cache_fifo_lru_writeback.sv
hw/rtl/acflw_checker.sv
dv/tb_top.sv
